@@ rtl/core/quaternion_vector_rotate_macros.svh @@
// Assertion macros for the quaternion vector rotate checker file.
// Depends on nothing; include by bare file name before the module.
`ifndef QUATERNION_VECTOR_ROTATE_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define QVR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked property that also holds during reset
`define QVR_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/qvr_pkg.sv @@
// Types and constants for the quaternion vector rotate pipeline.
// No dependencies; imported by every pipeline module and by the testbench.
package qvr_pkg;

    localparam int COMP_W      = 16;
    localparam int PROD1_W     = 2 * COMP_W;
    localparam int MVAL_W      = PROD1_W + 1;
    localparam int PROD2_W     = MVAL_W + COMP_W;
    localparam int RSUM_W      = PROD2_W + 2;
    localparam int ROUND_SHIFT = 28;
    localparam int RND_W       = RSUM_W - ROUND_SHIFT;
    localparam int IN_DATA_W   = 7 * COMP_W;
    localparam int OUT_DATA_W  = 3 * COMP_W;

    typedef logic signed [COMP_W-1:0]  comp_t;
    typedef logic signed [PROD1_W-1:0] prod1_t;
    typedef logic signed [MVAL_W-1:0]  mval_t;
    typedef logic signed [PROD2_W-1:0] prod2_t;
    typedef logic signed [RSUM_W-1:0]  rsum_t;
    typedef logic signed [RND_W-1:0]   rnd_t;

    typedef struct packed {
        comp_t z;
        comp_t y;
        comp_t x;
        comp_t w;
    } quat_t;

    typedef struct packed {
        comp_t z;
        comp_t y;
        comp_t x;
    } vec_t;

    // Left product p * (0, v), scale 2^14
    typedef struct packed {
        mval_t m3;
        mval_t m2;
        mval_t m1;
        mval_t m0;
    } mquat_t;

    // Rounded vector part before clipping
    typedef struct packed {
        rnd_t z;
        rnd_t y;
        rnd_t x;
    } rvec_t;

    // Final result payload
    typedef struct packed {
        logic  saturated;
        comp_t rot_z;
        comp_t rot_y;
        comp_t rot_x;
    } result_t;

    localparam rsum_t ROUND_HALF = rsum_t'(1) <<< (ROUND_SHIFT - 1);
    localparam rnd_t  RND_MAX    = rnd_t'(32767);
    localparam rnd_t  RND_MIN    = -rnd_t'(32768);
    localparam comp_t COMP_MAX   = comp_t'(16'h7FFF);
    localparam comp_t COMP_MIN   = comp_t'(16'h8000);

endpackage

@@ rtl/core/quaternion_vector_rotate.sv @@
// Quaternion vector rotation: rotates (vec_x, vec_y, vec_z) by the Q2.14
// quaternion (quat_w..quat_z) as p (0,v) conj(p), rounded to nearest (halves
// up) and saturated to 16 bits. The pipeline has five register stages: left
// products, left sums, right products, right sums with rounding, clipping.
// m_tvalid rises once a request has been registered through every stage up to
// the clipping stage; one request is taken every cycle while m_tready stays
// high, and a stalled output backs up the stages one by one, so empty stages
// keep taking requests. The quaternion is not normalized; a non-unit p
// scales the result by |p|^2.
// Depends on qvr_pkg, qvr_left_product, qvr_right_product, qvr_saturate.
module quaternion_vector_rotate (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z (16 bits each)
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rot_x, rot_y, rot_z (16 bits each)
    output logic [47:0]  m_tdata,
    // saturated
    output logic [0:0]   m_tuser
);
    import qvr_pkg::*;

    quat_t   in_quat;
    vec_t    in_vec;
    logic    l_valid;
    logic    l_ready;
    quat_t   l_quat;
    mquat_t  l_m;
    logic    r_valid;
    logic    r_ready;
    rvec_t   r_rnd;
    result_t result;

    // Unpack the request
    assign in_quat = s_tdata[4*COMP_W-1:0];
    assign in_vec  = s_tdata[IN_DATA_W-1:4*COMP_W];

    qvr_left_product u_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_quat   (in_quat),
        .in_vec    (in_vec),
        .out_valid (l_valid),
        .out_ready (l_ready),
        .out_quat  (l_quat),
        .out_m     (l_m)
    );

    qvr_right_product u_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (l_valid),
        .in_ready  (l_ready),
        .in_quat   (l_quat),
        .in_m      (l_m),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_rnd   (r_rnd)
    );

    qvr_saturate u_sat (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (r_valid),
        .in_ready   (r_ready),
        .in_rnd     (r_rnd),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    // Pack the result
    assign m_tdata    = {result.rot_z, result.rot_y, result.rot_x};
    assign m_tuser[0] = result.saturated;

endmodule

@@ rtl/core/qvr_left_product.sv @@
// Two pipeline stages for the left product m = p * (0, v).
// Depends on qvr_pkg.
module qvr_left_product (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  qvr_pkg::quat_t in_quat,
    input  qvr_pkg::vec_t  in_vec,
    output logic           out_valid,
    input  logic           out_ready,
    output qvr_pkg::quat_t out_quat,
    output qvr_pkg::mquat_t out_m
);
    import qvr_pkg::*;

    logic   va_reg;
    logic   vb_reg;
    logic   ready_a;
    logic   ready_b;
    prod1_t prod_reg [4][3];
    prod1_t prod_next [4][3];
    quat_t  qa_reg;
    quat_t  qb_reg;
    mquat_t m_reg;
    mquat_t m_next;

    // Advance each stage when the stage after it has room
    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    // Form the twelve component products
    always_comb
    begin
        prod_next[0][0] = prod1_t'(in_quat.x) * prod1_t'(in_vec.x);
        prod_next[0][1] = prod1_t'(in_quat.y) * prod1_t'(in_vec.y);
        prod_next[0][2] = prod1_t'(in_quat.z) * prod1_t'(in_vec.z);
        prod_next[1][0] = prod1_t'(in_quat.w) * prod1_t'(in_vec.x);
        prod_next[1][1] = prod1_t'(in_quat.y) * prod1_t'(in_vec.z);
        prod_next[1][2] = prod1_t'(in_quat.z) * prod1_t'(in_vec.y);
        prod_next[2][0] = prod1_t'(in_quat.w) * prod1_t'(in_vec.y);
        prod_next[2][1] = prod1_t'(in_quat.z) * prod1_t'(in_vec.x);
        prod_next[2][2] = prod1_t'(in_quat.x) * prod1_t'(in_vec.z);
        prod_next[3][0] = prod1_t'(in_quat.w) * prod1_t'(in_vec.z);
        prod_next[3][1] = prod1_t'(in_quat.x) * prod1_t'(in_vec.y);
        prod_next[3][2] = prod1_t'(in_quat.y) * prod1_t'(in_vec.x);
    end

    // Sum products into the four components of m
    always_comb
    begin
        m_next.m0 = mval_t'(0) - mval_t'(prod_reg[0][0]) - mval_t'(prod_reg[0][1])
                    - mval_t'(prod_reg[0][2]);
        m_next.m1 = mval_t'(prod_reg[1][0]) + mval_t'(prod_reg[1][1])
                    - mval_t'(prod_reg[1][2]);
        m_next.m2 = mval_t'(prod_reg[2][0]) + mval_t'(prod_reg[2][1])
                    - mval_t'(prod_reg[2][2]);
        m_next.m3 = mval_t'(prod_reg[3][0]) + mval_t'(prod_reg[3][1])
                    - mval_t'(prod_reg[3][2]);
    end

    // Track valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= in_valid;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            prod_reg <= prod_next;
            qa_reg   <= in_quat;
        end
        if (ready_b && va_reg)
        begin
            m_reg  <= m_next;
            qb_reg <= qa_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_quat  = qb_reg;
    assign out_m     = m_reg;

endmodule

@@ rtl/core/qvr_right_product.sv @@
// Two pipeline stages for the vector part of m * conj(p), rounded to integers.
// Depends on qvr_pkg.
module qvr_right_product (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qvr_pkg::quat_t  in_quat,
    input  qvr_pkg::mquat_t in_m,
    output logic            out_valid,
    input  logic            out_ready,
    output qvr_pkg::rvec_t  out_rnd
);
    import qvr_pkg::*;

    logic   va_reg;
    logic   vb_reg;
    logic   ready_a;
    logic   ready_b;
    prod2_t prod_reg [3][4];
    prod2_t prod_next [3][4];
    rsum_t  sum [3];
    rvec_t  rnd_reg;
    rvec_t  rnd_next;

    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    // Form products; terms ordered as + - - + in each row
    always_comb
    begin
        prod_next[0][0] = prod2_t'(in_m.m1) * prod2_t'(in_quat.w);
        prod_next[0][1] = prod2_t'(in_m.m0) * prod2_t'(in_quat.x);
        prod_next[0][2] = prod2_t'(in_m.m2) * prod2_t'(in_quat.z);
        prod_next[0][3] = prod2_t'(in_m.m3) * prod2_t'(in_quat.y);
        prod_next[1][0] = prod2_t'(in_m.m2) * prod2_t'(in_quat.w);
        prod_next[1][1] = prod2_t'(in_m.m0) * prod2_t'(in_quat.y);
        prod_next[1][2] = prod2_t'(in_m.m3) * prod2_t'(in_quat.x);
        prod_next[1][3] = prod2_t'(in_m.m1) * prod2_t'(in_quat.z);
        prod_next[2][0] = prod2_t'(in_m.m3) * prod2_t'(in_quat.w);
        prod_next[2][1] = prod2_t'(in_m.m0) * prod2_t'(in_quat.z);
        prod_next[2][2] = prod2_t'(in_m.m1) * prod2_t'(in_quat.y);
        prod_next[2][3] = prod2_t'(in_m.m2) * prod2_t'(in_quat.x);
    end

    // Sum with the rounding half, then drop the fraction (floor)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = rsum_t'(prod_reg[i][0]) - rsum_t'(prod_reg[i][1])
                     - rsum_t'(prod_reg[i][2]) + rsum_t'(prod_reg[i][3]) + ROUND_HALF;
        end
        rnd_next.x = rnd_t'(sum[0][RSUM_W-1:ROUND_SHIFT]);
        rnd_next.y = rnd_t'(sum[1][RSUM_W-1:ROUND_SHIFT]);
        rnd_next.z = rnd_t'(sum[2][RSUM_W-1:ROUND_SHIFT]);
    end

    // Track valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= in_valid;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    // Load payload registers
    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (ready_b && va_reg)
        begin
            rnd_reg <= rnd_next;
        end
    end

    assign out_valid = vb_reg;
    assign out_rnd   = rnd_reg;

endmodule

@@ rtl/core/qvr_saturate.sv @@
// Output stage: clip rounded components to 16 bits and flag any clipping.
// Depends on qvr_pkg.
module qvr_saturate (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  qvr_pkg::rvec_t   in_rnd,
    output logic             out_valid,
    input  logic             out_ready,
    output qvr_pkg::result_t out_result
);
    import qvr_pkg::*;

    logic    v_reg;
    logic    ready_o;
    result_t res_reg;
    result_t res_next;
    logic    sat_x;
    logic    sat_y;
    logic    sat_z;

    assign ready_o  = !v_reg || out_ready;
    assign in_ready = ready_o;

    // Clip each component
    always_comb
    begin
        sat_x = 1'b1;
        sat_y = 1'b1;
        sat_z = 1'b1;
        priority if (in_rnd.x > RND_MAX) res_next.rot_x = COMP_MAX;
        else if (in_rnd.x < RND_MIN)     res_next.rot_x = COMP_MIN;
        else
        begin
            res_next.rot_x = comp_t'(in_rnd.x[COMP_W-1:0]);
            sat_x          = 1'b0;
        end
        priority if (in_rnd.y > RND_MAX) res_next.rot_y = COMP_MAX;
        else if (in_rnd.y < RND_MIN)     res_next.rot_y = COMP_MIN;
        else
        begin
            res_next.rot_y = comp_t'(in_rnd.y[COMP_W-1:0]);
            sat_y          = 1'b0;
        end
        priority if (in_rnd.z > RND_MAX) res_next.rot_z = COMP_MAX;
        else if (in_rnd.z < RND_MIN)     res_next.rot_z = COMP_MIN;
        else
        begin
            res_next.rot_z = comp_t'(in_rnd.z[COMP_W-1:0]);
            sat_z          = 1'b0;
        end
        res_next.saturated = sat_x | sat_y | sat_z;
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (ready_o)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_o && in_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = v_reg;
    assign out_result = res_reg;

endmodule

@@ rtl/core/qvr_checker.sv @@
// Port-level checker for quaternion_vector_rotate, bound to the top level.
// Depends on quaternion_vector_rotate_macros.svh.
`include "quaternion_vector_rotate_macros.svh"

module qvr_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [47:0]  m_tdata,
    input logic [0:0]   m_tuser
);

    // No result may be offered after an edge taken in reset
    `QVR_ASSERT_RST(a_no_valid_in_reset, clk, !rst_n |=> !m_tvalid, "m_tvalid high after reset")

    // A stalled result holds
    `QVR_ASSERT_CLK(a_hold_stalled, clk, rst_n,
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "stalled result changed")

    // An empty output stage lets every stage take a request
    `QVR_ASSERT_CLK(a_ready_when_empty, clk, rst_n, !m_tvalid |-> s_tready, "s_tready low with output empty")

    // A saturation flag comes with a clipped component
    `QVR_ASSERT_CLK(a_sat_clipped, clk, rst_n,
        m_tvalid && m_tuser[0] |->
            m_tdata[15:0] == 16'h7FFF || m_tdata[15:0] == 16'h8000 ||
            m_tdata[31:16] == 16'h7FFF || m_tdata[31:16] == 16'h8000 ||
            m_tdata[47:32] == 16'h7FFF || m_tdata[47:32] == 16'h8000,
        "saturated without a clipped component")

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (.*);

@@ tb/sv/quaternion_vector_rotate_tb.sv @@
// Self-checking testbench for quaternion_vector_rotate: streams rotation requests,
// predicts each rotated vector in 64-bit integers and checks every output request.
// Depends on qvr_pkg and the quaternion_vector_rotate RTL.
module quaternion_vector_rotate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qvr_pkg::*;

    // One rotation request as it sits on s_tdata: quaternion low, vector high
    typedef struct packed {
        vec_t  v;
        quat_t q;
    } rot_request_t;

    localparam int     RANDOM_REQUESTS = 800;
    localparam int     IDLE_LIMIT      = 5000;
    localparam int     DRAIN_CYCLES    = 12;
    localparam longint ROUND_BIAS      = longint'(1) << (ROUND_SHIFT - 1);

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [47:0]  m_tdata;
    logic [0:0]   m_tuser;

    rot_request_t request_queue[$];
    result_t      expected_rotations[$];
    int           fail_count  = 0;
    logic         in_fire     = 1'b0;
    int           burst_left  = 0;
    int           gap_left    = 0;
    int           ready_mode  = 0;
    int           mode_cycles = 0;
    int           stall_left  = 0;
    int           idle_cycles = 0;

    quaternion_vector_rotate uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Compute p (0,v) conj(p) exactly, round halves up, clip to 16 bits
    function automatic result_t rotate_vector(rot_request_t req);
        longint pw, px, py, pz, vx, vy, vz;
        longint m0, m1, m2, m3;
        longint acc[3];
        longint rnd;
        comp_t  clipped[3];
        result_t res;
        int     k;
        pw = longint'(req.q.w);
        px = longint'(req.q.x);
        py = longint'(req.q.y);
        pz = longint'(req.q.z);
        vx = longint'(req.v.x);
        vy = longint'(req.v.y);
        vz = longint'(req.v.z);
        m0 = -(px * vx + py * vy + pz * vz);
        m1 = pw * vx + py * vz - pz * vy;
        m2 = pw * vy + pz * vx - px * vz;
        m3 = pw * vz + px * vy - py * vx;
        acc[0] = m1 * pw - m0 * px - m2 * pz + m3 * py;
        acc[1] = m2 * pw - m0 * py - m3 * px + m1 * pz;
        acc[2] = m3 * pw - m0 * pz - m1 * py + m2 * px;
        res.saturated = 1'b0;
        for (k = 0; k < 3; k++)
        begin
            rnd = (acc[k] + ROUND_BIAS) >>> ROUND_SHIFT;
            if (rnd > 32767)
            begin
                rnd = 32767;
                res.saturated = 1'b1;
            end
            if (rnd < -32768)
            begin
                rnd = -32768;
                res.saturated = 1'b1;
            end
            clipped[k] = comp_t'(rnd);
        end
        res.rot_x = clipped[0];
        res.rot_y = clipped[1];
        res.rot_z = clipped[2];
        return res;
    endfunction

    function automatic rot_request_t make_request(int w, int x, int y, int z,
                                                  int vx, int vy, int vz);
        rot_request_t req;
        req.q.w = comp_t'(w);
        req.q.x = comp_t'(x);
        req.q.y = comp_t'(y);
        req.q.z = comp_t'(z);
        req.v.x = comp_t'(vx);
        req.v.y = comp_t'(vy);
        req.v.z = comp_t'(vz);
        return req;
    endfunction

    // Random rotation, normalized to 1.0 = 16384
    function automatic quat_t random_unit_quat();
        real   a[4];
        real   norm;
        quat_t q;
        int    k;
        norm = 0.0;
        for (k = 0; k < 4; k++)
        begin
            a[k] = real'($urandom_range(0, 20000)) - 10000.0;
            norm = norm + a[k] * a[k];
        end
        if (norm == 0.0)
        begin
            a[0] = 1.0;
            norm = 1.0;
        end
        norm = $sqrt(norm);
        q.w = comp_t'($rtoi(a[0] / norm * 16384.0));
        q.x = comp_t'($rtoi(a[1] / norm * 16384.0));
        q.y = comp_t'($rtoi(a[2] / norm * 16384.0));
        q.z = comp_t'($rtoi(a[3] / norm * 16384.0));
        return q;
    endfunction

    function automatic comp_t corner_value();
        case ($urandom_range(0, 6))
            0: return comp_t'(0);
            1: return comp_t'(1);
            2: return comp_t'(-1);
            3: return COMP_MAX;
            4: return COMP_MIN;
            5: return comp_t'(16384);
            default: return comp_t'(-16384);
        endcase
    endfunction

    function automatic rot_request_t random_request();
        rot_request_t req;
        req.q   = random_unit_quat();
        req.v.x = comp_t'($urandom);
        req.v.y = comp_t'($urandom);
        req.v.z = comp_t'($urandom);
        case ($urandom_range(0, 19))
            // small vectors exercise rounding near zero
            0, 1, 2:
            begin
                req.v.x = comp_t'($urandom_range(0, 64) - 32);
                req.v.y = comp_t'($urandom_range(0, 64) - 32);
                req.v.z = comp_t'($urandom_range(0, 64) - 32);
            end
            // fully random words, mostly non-unit and saturating
            3, 4, 5:
                req.q = quat_t'({$urandom, $urandom});
            // corner components mixed in
            6, 7:
            begin
                req.q.w = corner_value();
                req.q.x = corner_value();
                req.q.y = corner_value();
                req.q.z = corner_value();
                req.v.x = corner_value();
                req.v.y = corner_value();
                req.v.z = corner_value();
            end
            // small quaternion: result shrinks toward zero
            8:
                req.q = make_request($urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256,
                                     $urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256,
                                     0, 0, 0).q;
            default: ;
        endcase
        return req;
    endfunction

    task automatic report_field(string name, int exp_val, int got_val);
        if (exp_val != got_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, got_val);
            fail_count++;
        end
    endtask

    // Hold a request until taken, then advance in bursts with random gaps
    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !in_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (request_queue.size() > 0)
            begin
                s_tdata  <= request_queue.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output stall pattern: switch style every so often
    always @(negedge clk)
    begin
        if (mode_cycles == 0)
        begin
            ready_mode  = $urandom_range(0, 3);
            mode_cycles = $urandom_range(20, 120);
        end
        mode_cycles--;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2:
            begin
                if (stall_left == 0)
                    stall_left = $urandom_range(1, 10);
                stall_left--;
                m_tready <= (stall_left % 2 == 0) ? $urandom_range(0, 1) : 1'b0;
            end
            default: m_tready <= (mode_cycles % 3 == 0);
        endcase
    end

    // Predict on request acceptance, check on result acceptance
    always @(posedge clk)
    begin
        in_fire <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_rotations.push_back(rotate_vector(rot_request_t'(s_tdata)));
            if (m_tvalid && m_tready)
            begin
                if (expected_rotations.size() == 0)
                begin
                    $display("%0t: unexpected result, actual rot=(%0d,%0d,%0d) sat=%0b",
                             $time, $signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
                             $signed(m_tdata[47:32]), m_tuser[0]);
                    fail_count++;
                end
                else
                begin
                    result_t exp_res;
                    exp_res = expected_rotations.pop_front();
                    report_field("rot_x", exp_res.rot_x, $signed(m_tdata[15:0]));
                    report_field("rot_y", exp_res.rot_y, $signed(m_tdata[31:16]));
                    report_field("rot_z", exp_res.rot_z, $signed(m_tdata[47:32]));
                    report_field("saturated", exp_res.saturated, m_tuser[0]);
                end
            end
        end
    end

    // Watchdog: stop when no request moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout with %0d requests pending and %0d results outstanding",
                         $time, request_queue.size(), expected_rotations.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        // identity and its negation leave the vector unchanged
        request_queue.push_back(make_request(16384, 0, 0, 0, 1, -1, 0));
        request_queue.push_back(make_request(16384, 0, 0, 0, 32767, -32768, 32767));
        request_queue.push_back(make_request(16384, 0, 0, 0, -32768, 32767, -32768));
        request_queue.push_back(make_request(-16384, 0, 0, 0, 100, 200, 300));
        // zero quaternion gives zero
        request_queue.push_back(make_request(0, 0, 0, 0, 32767, -32768, 32767));
        // extreme components, heavy saturation
        request_queue.push_back(make_request(-32768, -32768, -32768, -32768,
                                             -32768, -32768, -32768));
        request_queue.push_back(make_request(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        request_queue.push_back(make_request(-32768, 32767, -32768, 32767,
                                             32767, -32768, 32767));
        // quarter turns about each axis
        request_queue.push_back(make_request(11585, 11585, 0, 0, 1000, 2000, 3000));
        request_queue.push_back(make_request(11585, 0, 11585, 0, 1000, 2000, 3000));
        request_queue.push_back(make_request(11585, 0, 0, 11585, 1000, 2000, 3000));
        request_queue.push_back(make_request(11585, 0, 0, -11585, -32768, 32767, 5));
        // half turn about x negates -32768 on y and z: out of range
        request_queue.push_back(make_request(0, 16384, 0, 0, -32768, -32768, -32768));
        // |p|^2 = 1/4: exact halves round up, quarters round to nearest
        request_queue.push_back(make_request(8192, 0, 0, 0, 2, -2, 1));
        request_queue.push_back(make_request(8192, 0, 0, 0, 6, -6, -3));
        request_queue.push_back(make_request(8192, 0, 0, 0, -1, 3, -7));
        // non-unit scale of about two
        request_queue.push_back(make_request(23170, 0, 0, 0, 20000, -20000, 100));
        // tiny quaternions, then alternating bit patterns
        request_queue.push_back(make_request(1, 1, 1, 1, 32767, -32768, 32767));
        request_queue.push_back(make_request(1, 0, 0, 0, 32767, 32767, -32768));
        request_queue.push_back(make_request(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                             16'hAAAA, 16'h5555, 16'hAAAA));
        for (n = 0; n < RANDOM_REQUESTS; n++)
            request_queue.push_back(random_request());

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() > 0 || s_tvalid)
            @(posedge clk);
        while (expected_rotations.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
